>>> hdl/timed_linear_fade_in_unit_defines.svh
// ----------------------------------------------------------------------------
// Timed linear fade-in: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_LINEAR_FADE_IN_UNIT_DEFINES_SVH
`define TIMED_LINEAR_FADE_IN_UNIT_DEFINES_SVH

// same-cycle implication
`define TLF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_pkg
// Types and constants shared by the fade-in controller, datapath and ports.
// ----------------------------------------------------------------------------
package tlf_pkg;

	localparam int NUM_FIELDS   = 4;
	localparam int DEF_CHANNELS = 4;
	localparam int FRAC_W       = 16;
	localparam int FIELD_IW     = $clog2(NUM_FIELDS);

	localparam logic [15:0] FADE_TIME_RST = 16'd1000;

	// command codes
	localparam logic CMD_ENTER  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic               command;
		logic        [31:0] now_ms;
		logic signed [15:0] value_0;
		logic signed [15:0] value_1;
		logic signed [15:0] value_2;
		logic signed [15:0] value_3;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] out_0;
		logic signed [15:0] out_1;
		logic signed [15:0] out_2;
		logic signed [15:0] out_3;
		logic               fading;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic enter;
		logic disarm;
		logic div_start;
		logic div_step;
		logic mac_step;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_enter;
		logic armed;
		logic over;
		logic div_last;
		logic mac_last;
	} dp_sts_t;

endpackage

>>> hdl/tlf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_in_if / tlf_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface tlf_in_if;
	logic              valid;
	logic              ready;
	tlf_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tlf_out_if;
	logic               valid;
	logic               ready;
	tlf_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/tlf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_dpath
// Fade datapath: fade state, restoring blend divider, channel-serial blend
// multiply/accumulate and the result word register.
// ----------------------------------------------------------------------------
module tlf_dpath #(
	parameter int CHANNELS = tlf_pkg::DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  tlf_pkg::in_word_t  item_data,
	output tlf_pkg::out_word_t result_data,
	input  tlf_pkg::dp_cmd_t   cmd,
	output tlf_pkg::dp_sts_t   sts
);
	import tlf_pkg::*;

	// channels that keep a level
	localparam int ACTIVE = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;
	localparam int IW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
	localparam int CW     = $clog2(ACTIVE + 1);
	localparam int DW     = $clog2(FRAC_W);

	localparam logic [CW-1:0]     MAC_LAST = CW'(ACTIVE);
	localparam logic [DW-1:0]     DIV_LAST = DW'(FRAC_W - 1);
	localparam logic [FRAC_W:0]   ONE_Q16  = (FRAC_W + 1)'(1) << FRAC_W;

	// integer part of a Q16.16 level, toward zero
	function automatic logic [15:0] trunc_q16(input logic [31:0] lvl);
		trunc_q16 = lvl[31:16] + 16'(lvl[31] && (lvl[15:0] != 16'h0));
	endfunction

	logic [15:0]        fade_time_q;
	logic [31:0]        start_q;
	logic               armed_q;
	logic               command_q;
	logic [31:0]        now_q;
	logic signed [15:0] val_q [NUM_FIELDS];
	logic signed [15:0] res_q [NUM_FIELDS];
	logic signed [31:0] lvl_q [ACTIVE];

	logic [FRAC_W-1:0]  rem_q;
	logic [FRAC_W-1:0]  quo_q;
	logic [DW-1:0]      div_cnt_q;
	logic [CW-1:0]      mac_cnt_q;

	logic signed [49:0] pa_s1;
	logic signed [32:0] pb_s1;
	logic [IW-1:0]      idx_s1;
	logic               vld_s1;

	out_word_t          result_q;

	logic [31:0]        elapsed;
	logic [FRAC_W:0]    rem_dbl;
	logic [FRAC_W:0]    inv_blend;
	logic [IW-1:0]      rd_idx;
	logic [31:0]        lvl_new;

	assign elapsed   = now_q - start_q;
	assign rem_dbl   = {rem_q, 1'b0};
	assign inv_blend = ONE_Q16 - {1'b0, quo_q};
	assign rd_idx    = mac_cnt_q[IW-1:0];
	assign lvl_new   = pb_s1[31:0] + pa_s1[47:16];

	// status
	always_comb begin
		sts.is_enter = (command_q == CMD_ENTER);
		sts.armed    = armed_q;
		sts.over     = (fade_time_q == 16'h0) || (elapsed >= {16'h0, fade_time_q});
		sts.div_last = (div_cnt_q == DIV_LAST);
		sts.mac_last = (mac_cnt_q == MAC_LAST);
	end

	// configuration and fade control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_time_q <= FADE_TIME_RST;
			start_q     <= '0;
			armed_q     <= 1'b1;
		end else begin
			if (cfg_wr_en) fade_time_q <= cfg_wr_data;
			if (cmd.enter) begin
				start_q <= now_q;
				armed_q <= 1'b1;
			end else if (cmd.disarm) begin
				armed_q <= 1'b0;
			end
		end
	end

	// captured word and per-field results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= item_data.command;
			now_q     <= item_data.now_ms;
			val_q[0]  <= item_data.value_0;
			val_q[1]  <= item_data.value_1;
			val_q[2]  <= item_data.value_2;
			val_q[3]  <= item_data.value_3;
			res_q[0]  <= item_data.value_0;
			res_q[1]  <= item_data.value_1;
			res_q[2]  <= item_data.value_2;
			res_q[3]  <= item_data.value_3;
		end else if (vld_s1) begin
			res_q[FIELD_IW'(idx_s1)] <= trunc_q16(lvl_new);
		end
	end

	// channel levels, Q16.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE; i++) lvl_q[i] <= '0;
		end else if (cmd.enter) begin
			for (int i = 0; i < ACTIVE; i++) lvl_q[i] <= {val_q[i], 16'h0};
		end else if (vld_s1) begin
			lvl_q[idx_s1] <= lvl_new;
		end
	end

	// restoring divider: blend = (elapsed << 16) / fade_time, one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			mac_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
			mac_cnt_q <= '0;
		end else begin
			if (cmd.div_step) div_cnt_q <= div_cnt_q + DW'(1);
			if (cmd.mac_step && !sts.mac_last) mac_cnt_q <= mac_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= elapsed[FRAC_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_dbl >= {1'b0, fade_time_q}) begin
				rem_q <= FRAC_W'(rem_dbl - {1'b0, fade_time_q});
				quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_dbl[FRAC_W-1:0];
				quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
			end
		end
	end

	// blend products for one channel a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= cmd.mac_step && !sts.mac_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_step && !sts.mac_last) begin
			pa_s1  <= $signed({1'b0, inv_blend}) * lvl_q[rd_idx];
			pb_s1  <= $signed({1'b0, quo_q}) * val_q[FIELD_IW'(rd_idx)];
			idx_s1 <= rd_idx;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.out_0  <= res_q[0];
			result_q.out_1  <= res_q[1];
			result_q.out_2  <= res_q[2];
			result_q.out_3  <= res_q[3];
			result_q.fading <= armed_q;
		end
	end

	assign result_data = result_q;

`include "timed_linear_fade_in_unit_defines.svh"

	`TLF_ASSERT_IMP(a_div_rem_bound, cmd.div_step, rem_q < fade_time_q, "divider remainder out of range")
	`TLF_ASSERT_IMP(a_mac_idx_range, vld_s1, int'(idx_s1) < ACTIVE, "blend write past active channels")
	`TLF_ASSERT_NXT(a_mac_drain, cmd.mac_step && sts.mac_last, !vld_s1, "blend pipe not drained")

endmodule

>>> hdl/tlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_ctrl
// Fade controller: checks each accepted word, sequences divide and blend when
// it is a blending sample, and owns the result word handshake.
// ----------------------------------------------------------------------------
module tlf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tlf_pkg::dp_cmd_t cmd,
	input  tlf_pkg::dp_sts_t sts
);
	import tlf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIV,
		ST_MAC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.capture = in_valid;
			ST_CHK: begin
				if (sts.is_enter)            cmd.enter     = 1'b1;
				else if (sts.armed && sts.over)  cmd.disarm    = 1'b1;
				else if (sts.armed)          cmd.div_start = 1'b1;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_MAC:  cmd.mac_step = 1'b1;
			ST_FIN:  cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CHK;
				ST_CHK:  state_q <= cmd.div_start ? ST_DIV : ST_FIN;
				ST_DIV:  if (sts.div_last) state_q <= ST_MAC;
				ST_MAC:  if (sts.mac_last) state_q <= ST_FIN;
				ST_FIN:  if (cmd.out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "timed_linear_fade_in_unit_defines.svh"

	`TLF_ASSERT_NXT(a_accept_to_chk, in_valid && in_ready, state_q == ST_CHK, "accepted word not checked")
	`TLF_ASSERT_NXT(a_fin_delivers, state_q == ST_FIN && !out_valid_q, out_valid_q && state_q == ST_IDLE, "free result slot not loaded")
	`TLF_ASSERT_IMP(a_idle_quiet, in_ready, !(cmd.div_step || cmd.mac_step || cmd.out_load), "datapath busy while idle")

endmodule

>>> hdl/timed_linear_fade_in_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_linear_fade_in_unit
// Linear fade-in of up to four channels from captured levels toward live
// targets over a programmable time in milliseconds.
// ----------------------------------------------------------------------------
// One word is worked at a time. An enter word, a sample while the fade is not
// armed, and the sample that ends the fade go from the check straight to the
// result. For a blending sample a restoring divider forms the Q0.16 blend
// fraction, then one shared multiplier pair works one channel a cycle and the
// blend pipe drains. The result sits in an output register, so a new word is
// taken while the previous result waits. The user must write fade_time_ms
// through cfg_wr_en/cfg_wr_data only while the unit is idle; the unit itself
// does not enforce this.
module timed_linear_fade_in_unit #(
	parameter int CHANNELS = tlf_pkg::DEF_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	tlf_in_if.sink      item,
	tlf_out_if.source   result
);
	import tlf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tlf_dpath #(
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_data   (item.data),
		.result_data (result.data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
